@@ rtl/fsub_pkg.sv @@
`default_nettype none
package fsub_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned ExpW = 8;
	localparam int unsigned FracW = 23;
	localparam int unsigned ManW = FracW + 1;
	localparam int unsigned SumW = ManW + 1;
	localparam int unsigned LzW = 5;
	localparam logic [ManW-1:0] HiddenBit = {1'b1, {FracW{1'b0}}};

	function automatic logic [LzW-1:0] lead_zeros(input logic [ManW-1:0] v);
		logic [LzW-1:0] n;
		logic found;
		n = '0;
		found = 1'b0;
		for (int i = ManW - 1; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = LzW'(ManW - 1 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

@@ rtl/float32_subtractor.sv @@
// channel | signals                                  | direction
// in      | in_valid, in_stall, operand_a/b, enable  | word into block
// out     | out_valid, out_stall, difference         | word out of block
// Four register stages: order/align, add, leading-zero count, normalize.
// One word per cycle while out_stall does not hold the pipeline.
// arst_n clears all stage valid bits; payload registers are not reset.
// out_stall holds a full pipeline; empty stages keep taking words.
`default_nettype none
module float32_subtractor import fsub_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [WordW-1:0] operand_a,
	input  wire logic [WordW-1:0] operand_b,
	input  wire logic             enable,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [WordW-1:0]      difference
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;
	assign adv4 = !v_s4 || !out_stall;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	// stage 1: order and align
	logic a_big, sign_b, rsign_c, eff_sub_c;
	logic [WordW-1:0] big, sml;
	logic [ExpW-1:0] ediff;
	logic [ManW-1:0] aligned;
	assign sign_b = ~operand_b[WordW-1];
	assign a_big = operand_a[WordW-2:0] > operand_b[WordW-2:0];
	assign big = a_big ? operand_a : operand_b;
	assign sml = a_big ? operand_b : operand_a;
	assign rsign_c = a_big ? operand_a[WordW-1] : sign_b;
	assign eff_sub_c = operand_a[WordW-1] != sign_b;
	assign ediff = big[WordW-2:FracW] - sml[WordW-2:FracW];
	assign aligned = (ediff >= ExpW'(ManW)) ? '0 :
		((HiddenBit | {1'b0, sml[FracW-1:0]}) >> ediff);

	logic en_s1, sign_s1, sub_s1;
	logic [ExpW-1:0] e_s1;
	logic [ManW-1:0] mb_s1, ms_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			en_s1 <= enable;
			sign_s1 <= rsign_c;
			sub_s1 <= eff_sub_c;
			e_s1 <= big[WordW-2:FracW];
			mb_s1 <= HiddenBit | {1'b0, big[FracW-1:0]};
			ms_s1 <= aligned;
		end
	end

	// stage 2: add
	logic en_s2, sign_s2;
	logic [ExpW-1:0] e_s2;
	logic [SumW-1:0] sum_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			en_s2 <= en_s1;
			sign_s2 <= sign_s1;
			e_s2 <= e_s1;
			sum_s2 <= sub_s1 ? ({1'b0, mb_s1} - {1'b0, ms_s1})
				: ({1'b0, mb_s1} + {1'b0, ms_s1});
		end
	end

	// stage 3: leading zeros
	logic en_s3, sign_s3;
	logic [ExpW-1:0] e_s3;
	logic [SumW-1:0] sum_s3;
	logic [LzW-1:0] lz_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv3) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			en_s3 <= en_s2;
			sign_s3 <= sign_s2;
			e_s3 <= e_s2;
			sum_s3 <= sum_s2;
			lz_s3 <= lead_zeros(sum_s2[ManW-1:0]);
		end
	end

	// stage 4: normalize
	logic [WordW-1:0] res_c;
	logic [ManW-1:0] shifted;
	assign shifted = sum_s3[ManW-1:0] << lz_s3;
	always_comb begin
		if (!en_s3 || sum_s3 == '0) begin
			res_c = '0;
		end else if (sum_s3[SumW-1]) begin
			res_c = {sign_s3, e_s3 + ExpW'(1), sum_s3[FracW:1]};
		end else if (ExpW'(lz_s3) > e_s3) begin
			res_c = {sign_s3, {(WordW-1){1'b0}}};
		end else begin
			res_c = {sign_s3, e_s3 - ExpW'(lz_s3), shifted[FracW-1:0]};
		end
	end

	logic [WordW-1:0] res_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv4) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv4 && v_s3) res_s4 <= res_c;
	end
	assign out_valid = v_s4;
	assign difference = res_s4;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(difference))
		else $error("output word changed under stall");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && adv4 && !en_s3 |=> difference == '0)
		else $error("disabled word not zero");
endmodule
`default_nettype wire

@@ test/float32_subtractor_tb.sv @@
`default_nettype none
module float32_subtractor_tb;
	import fsub_pkg::*;

	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic             en;
	} sub_word_t;

	localparam int unsigned LimitCycles = 200000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [WordW-1:0] operand_a = '0;
	logic [WordW-1:0] operand_b = '0;
	logic             enable = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [WordW-1:0] difference;

	sub_word_t        pending_words[$];
	logic [WordW-1:0] expected_diffs[$];
	int               mismatches = 0;
	int               cycles = 0;
	bit               quiet_phase = 1'b0;
	bit               hold_req = 1'b0;
	bit               pause_req = 1'b0;
	int               hold_count = 0;

	float32_subtractor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operand_a(operand_a), .operand_b(operand_b), .enable(enable),
		.out_valid(out_valid), .out_stall(out_stall), .difference(difference)
	);

	always #4 clk = ~clk;

	function automatic logic [WordW-1:0] sub_bits(input logic [WordW-1:0] a,
			input logic [WordW-1:0] b, input logic en);
		logic             sa, sb, rs;
		logic [WordW-1:0] big, sml;
		logic [ExpW-1:0]  eb, es, ed;
		logic [SumW-1:0]  al, sm;
		logic [WordW-1:0] res;
		int               lz;
		if (!en)
			return '0;
		sa = a[31];
		sb = ~b[31];
		if (a[30:0] > b[30:0]) begin
			big = a; sml = b; rs = sa;
		end else begin
			big = b; sml = a; rs = sb;
		end
		eb = big[30:23];
		es = sml[30:23];
		ed = eb - es;
		al = {2'b01, sml[22:0]};
		al = (ed >= 24) ? '0 : (al >> ed);
		sm = {2'b01, big[22:0]};
		sm = (sa == sb) ? sm + al : sm - al;
		if (sm == 0)
			return '0;
		lz = 0;
		for (int i = 0; i <= 23; i++)
			if (sm[i])
				lz = 23 - i;
		if (sm[24])
			res = {1'b0, eb + 8'd1, sm[23:1]};
		else if (lz > eb)
			res = '0;
		else begin
			sm = sm << lz;
			res = {1'b0, eb - 8'(lz), sm[22:0]};
		end
		res[31] = rs;
		return res;
	endfunction

	function automatic logic [WordW-1:0] rand_float();
		logic [WordW-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 4))
			0: v[22:0] = ($urandom_range(0, 1)) ? '0 : '1;
			1: v[30:23] = ($urandom_range(0, 1)) ? 8'd0 : 8'd255;
			default: ;
		endcase
		return v;
	endfunction

	task automatic add_word(input logic [WordW-1:0] a, input logic [WordW-1:0] b,
			input logic en);
		pending_words.push_back('{a: a, b: b, en: en});
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_diffs.push_back(sub_bits(operand_a, operand_b, enable));
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && !pause_req &&
						(quiet_phase || $urandom_range(0, 99) >= 35)) begin
					in_valid <= 1'b1;
					operand_a <= pending_words[0].a;
					operand_b <= pending_words[0].b;
					enable <= pending_words[0].en;
					void'(pending_words.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_diffs.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected word %h", difference);
				end else begin
					if (difference !== expected_diffs[0]) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: expected %h actual %h",
								expected_diffs[0], difference);
					end
					void'(expected_diffs.pop_front());
				end
			end
			if (hold_req && hold_count < 60) begin
				hold_count <= hold_count + 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_phase && ($urandom_range(0, 99) < 35);
			end
		end
	end

	initial begin
		add_word(32'h3F80_0000, 32'h3F80_0000, 1'b1);
		add_word(32'h3F80_0000, 32'hBF80_0000, 1'b1);
		add_word(32'h4000_0000, 32'h3F80_0000, 1'b1);
		add_word(32'h3F80_0000, 32'h4000_0000, 1'b1);
		add_word(32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
		add_word(32'h4B80_0000, 32'h3F80_0000, 1'b1);
		add_word(32'h7F80_0000, 32'h3F80_0000, 1'b1);
		add_word(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		add_word(32'h0080_0001, 32'h0080_0000, 1'b1);
		add_word(32'h0000_0001, 32'h0000_0000, 1'b1);
		add_word(32'h0000_0000, 32'h0000_0000, 1'b1);
		add_word(32'h8000_0000, 32'h0000_0000, 1'b1);
		add_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		add_word(32'h3FFF_FFFF, 32'h3F80_0001, 1'b1);
		add_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		add_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		add_word(32'h4C00_0000, 32'h3F80_0000, 1'b1);
		add_word(32'h4B7F_FFFF, 32'hBF80_0000, 1'b1);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_words.size() == 0);
		for (int i = 0; i < 530; i++) begin
			logic [WordW-1:0] a, b;
			a = rand_float();
			b = ($urandom_range(0, 3) == 0) ? a ^ (32'($urandom_range(0, 1)) << 31) :
				($urandom_range(0, 2) == 0) ? {1'($urandom), a[30:23], 23'($urandom)} :
				rand_float();
			if ($urandom_range(0, 3) == 0)
				b[30:23] = a[30:23] + 8'($urandom_range(0, 3)) - 8'd1;
			add_word(a, b, $urandom_range(0, 9) != 0);
			if (i == 100) begin
				hold_req <= 1'b1;
				wait (pending_words.size() == 0);
				wait (hold_count >= 60);
				hold_req <= 1'b0;
			end
			if (i == 200) begin
				pause_req <= 1'b1;
				@(posedge clk);
				wait (!in_valid && expected_diffs.size() == 0);
				pause_req <= 1'b0;
			end
			if (i == 300)
				quiet_phase <= 1'b1;
			if (i == 400) begin
				wait (pending_words.size() == 0);
				quiet_phase <= 1'b0;
			end
		end
		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (!in_valid && expected_diffs.size() == 0);
		repeat (12) @(posedge clk);
		if (mismatches == 0 && expected_diffs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		wait (cycles >= LimitCycles);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
